// ===== src/bpc_pkg.sv =====
package bpc_pkg;

  localparam int LockoutWidth = 10;
  localparam int SampleWidth  = 6;
  localparam int RunWidth     = 4;
  localparam int TicksWidth   = 11;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 11;

  localparam logic [LockoutWidth-1:0] LOCKOUT_RESET = 10'd150;
  localparam logic [SampleWidth-1:0]  SAMPLE_RESET  = 6'd5;
  localparam logic [RunWidth-1:0]     RELEASE_RESET = 4'd5;
  localparam logic [TicksWidth-1:0]   LONG_RESET    = 11'd1000;
  localparam logic [TicksWidth-1:0]   SHORT_RESET   = 11'd50;
  localparam logic [RunWidth-1:0]     RUN_MAX       = 4'hF;

  localparam logic PRESS_SHORT = 1'b0;
  localparam logic PRESS_LONG  = 1'b1;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LOCKOUT_TICKS   = 3'd0,
    CFG_SAMPLE_TICKS    = 3'd1,
    CFG_RELEASE_SAMPLES = 3'd2,
    CFG_LONG_TICKS      = 3'd3,
    CFG_SHORT_TICKS     = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic press_edge;
    logic pin_level;
  } tick_t;

  typedef struct packed {
    logic                  press_kind;
    logic [TicksWidth-1:0] held_ticks;
  } press_t;

  typedef struct packed {
    logic [LockoutWidth-1:0] lockout_ticks;
    logic [SampleWidth-1:0]  sample_ticks;
    logic [RunWidth-1:0]     release_samples;
    logic [TicksWidth-1:0]   long_ticks;
    logic [TicksWidth-1:0]   short_ticks;
  } cfg_t;

  typedef struct packed {
    logic   valid;
    press_t data;
  } result_t;

endpackage

// ===== src/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic [bpc_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataWidth-1:0]  cfg_data,
  output bpc_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lockout_ticks   <= bpc_pkg::LOCKOUT_RESET;
      cfg.sample_ticks    <= bpc_pkg::SAMPLE_RESET;
      cfg.release_samples <= bpc_pkg::RELEASE_RESET;
      cfg.long_ticks      <= bpc_pkg::LONG_RESET;
      cfg.short_ticks     <= bpc_pkg::SHORT_RESET;
    end else if (cfg_valid) begin
      case (bpc_pkg::cfg_reg_t'(cfg_index))
        bpc_pkg::CFG_LOCKOUT_TICKS:
          cfg.lockout_ticks <= cfg_data[bpc_pkg::LockoutWidth-1:0];
        bpc_pkg::CFG_SAMPLE_TICKS:
          cfg.sample_ticks <= cfg_data[bpc_pkg::SampleWidth-1:0];
        bpc_pkg::CFG_RELEASE_SAMPLES:
          cfg.release_samples <= cfg_data[bpc_pkg::RunWidth-1:0];
        bpc_pkg::CFG_LONG_TICKS:
          cfg.long_ticks <= cfg_data[bpc_pkg::TicksWidth-1:0];
        bpc_pkg::CFG_SHORT_TICKS:
          cfg.short_ticks <= cfg_data[bpc_pkg::TicksWidth-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== src/bpc_core.sv =====
module bpc_core (
  input  logic             clk,
  input  logic             rst,
  input  bpc_pkg::cfg_t    cfg,
  input  bpc_pkg::tick_t   item,
  input  logic             step,
  output bpc_pkg::result_t res
);

  logic                               measuring;
  logic                               measuring_next;
  logic [bpc_pkg::TicksWidth-1:0]     elapsed;
  logic [bpc_pkg::TicksWidth-1:0]     elapsed_next;
  logic [bpc_pkg::SampleWidth-1:0]    sample_phase;
  logic [bpc_pkg::SampleWidth-1:0]    sample_phase_next;
  logic [bpc_pkg::RunWidth-1:0]       release_run;
  logic [bpc_pkg::RunWidth-1:0]       release_run_next;
  logic [bpc_pkg::LockoutWidth-1:0]   lockout_left;
  logic [bpc_pkg::LockoutWidth-1:0]   lockout_left_next;

  logic                               go;
  logic [bpc_pkg::LockoutWidth-1:0]   lockout_dec;
  logic [bpc_pkg::TicksWidth-1:0]     el_cur;
  logic [bpc_pkg::SampleWidth-1:0]    ph_cur;
  logic [bpc_pkg::RunWidth-1:0]       rr_cur;
  logic [bpc_pkg::TicksWidth:0]       el_inc;
  logic [bpc_pkg::TicksWidth-1:0]     el_new;
  logic [bpc_pkg::SampleWidth-1:0]    ph_new;
  logic [bpc_pkg::RunWidth-1:0]       rr_new;

  always_comb begin
    measuring_next    = measuring;
    elapsed_next      = elapsed;
    sample_phase_next = sample_phase;
    release_run_next  = release_run;
    lockout_left_next = lockout_left;
    res               = '0;

    lockout_dec = (lockout_left != '0) ? lockout_left - 1'b1 : lockout_left;
    go     = measuring;
    el_cur = elapsed;
    ph_cur = sample_phase;
    rr_cur = release_run;

    if (!measuring) begin
      lockout_left_next = lockout_dec;
      if (item.press_edge && lockout_dec == '0) begin
        go     = 1'b1;
        el_cur = '0;
        ph_cur = '0;
        rr_cur = '0;
      end
    end

    rr_new = rr_cur;
    if (ph_cur == '0) begin
      if (item.pin_level) begin
        rr_new = (rr_cur == bpc_pkg::RUN_MAX) ? rr_cur : rr_cur + 1'b1;
      end else begin
        rr_new = '0;
      end
    end

    el_inc = {1'b0, el_cur} + 1'b1;
    el_new = (el_inc > {1'b0, cfg.long_ticks}) ? cfg.long_ticks
                                               : el_inc[bpc_pkg::TicksWidth-1:0];
    ph_new = ph_cur + 1'b1;

    if (go) begin
      measuring_next    = 1'b1;
      elapsed_next      = el_new;
      release_run_next  = rr_new;
      sample_phase_next = ph_new;
      if (ph_new >= cfg.sample_ticks) begin
        sample_phase_next = '0;
        if (rr_new >= cfg.release_samples || el_new >= cfg.long_ticks) begin
          measuring_next    = 1'b0;
          lockout_left_next = cfg.lockout_ticks;
          release_run_next  = '0;
          res.data.held_ticks = el_new;
          if (el_new >= cfg.long_ticks) begin
            res.valid           = 1'b1;
            res.data.press_kind = bpc_pkg::PRESS_LONG;
          end else if (el_new >= cfg.short_ticks) begin
            res.valid           = 1'b1;
            res.data.press_kind = bpc_pkg::PRESS_SHORT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measuring    <= 1'b0;
      elapsed      <= '0;
      sample_phase <= '0;
      release_run  <= '0;
      lockout_left <= '0;
    end else if (step) begin
      measuring    <= measuring_next;
      elapsed      <= elapsed_next;
      sample_phase <= sample_phase_next;
      release_run  <= release_run_next;
      lockout_left <= lockout_left_next;
    end
  end

endmodule

// ===== src/bpc_out_reg.sv =====
module bpc_out_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  bpc_pkg::press_t data,
  output logic            free,
  output logic            press_valid,
  input  logic            press_stall,
  output bpc_pkg::press_t press
);

  logic press_valid_next;

  assign free = !press_valid || !press_stall;

  always_comb begin
    press_valid_next = press_valid;
    if (load) begin
      press_valid_next = 1'b1;
    end else if (!press_stall) begin
      press_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_valid <= 1'b0;
    end else begin
      press_valid <= press_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      press <= data;
    end
  end

endmodule

// ===== src/button_press_classifier.sv =====
// Debounced short/long press detector. Each tick request carries the press
// edge flag and the pin level; one request is taken per clock cycle while
// tick_stall is low. A tick is held in the input register, and its state
// update and classification run combinationally on it; a press report is
// loaded into the output register as the tick advances. The rate is set by
// the state update loop in the core: one tick per cycle unless a report is
// held by press_stall. Configuration writes are taken at any time (cfg_ready
// is always high) and must only be issued while no ticks are in flight.
module button_press_classifier (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  output logic                              tick_stall,
  input  bpc_pkg::tick_t                    tick,
  output logic                              press_valid,
  input  logic                              press_stall,
  output bpc_pkg::press_t                   press,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CfgIdxWidth-1:0]   cfg_index,
  input  logic [bpc_pkg::CfgDataWidth-1:0]  cfg_data
);

  bpc_pkg::cfg_t    cfg;
  bpc_pkg::tick_t   in_item;
  bpc_pkg::result_t res;
  logic             in_full;
  logic             in_full_next;
  logic             accept;
  logic             advance;
  logic             out_free;

  assign cfg_ready  = 1'b1;
  assign advance    = in_full && (!res.valid || out_free);
  assign tick_stall = in_full && !advance;
  assign accept     = tick_valid && !tick_stall;

  always_comb begin
    in_full_next = in_full;
    if (accept) begin
      in_full_next = 1'b1;
    end else if (advance) begin
      in_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= in_full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= tick;
    end
  end

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bpc_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (in_item),
    .step (advance),
    .res  (res)
  );

  bpc_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && res.valid),
    .data        (res.data),
    .free        (out_free),
    .press_valid (press_valid),
    .press_stall (press_stall),
    .press       (press)
  );

endmodule

// ===== verif/button_press_classifier_test.sv =====
`timescale 1ns / 100ps

module button_press_classifier_test;
  import bpc_pkg::*;

  localparam logic PIN_PRESSED  = 1'b0;
  localparam logic PIN_RELEASED = 1'b1;
  localparam logic [CfgIdxWidth-1:0] CFG_UNUSED = 3'd7;

  class press_tracker;
    logic [LockoutWidth-1:0] lockout_ticks;
    logic [SampleWidth-1:0]  sample_ticks;
    logic [RunWidth-1:0]     release_samples;
    logic [TicksWidth-1:0]   long_ticks;
    logic [TicksWidth-1:0]   short_ticks;
    logic                    measuring;
    logic [TicksWidth-1:0]   elapsed;
    logic [SampleWidth-1:0]  sample_phase;
    logic [RunWidth-1:0]     release_run;
    logic [LockoutWidth-1:0] lockout_left;
    press_t                  expected_presses[$];
    int                      errors;
    int                      matched;

    function new();
      lockout_ticks   = LOCKOUT_RESET;
      sample_ticks    = SAMPLE_RESET;
      release_samples = RELEASE_RESET;
      long_ticks      = LONG_RESET;
      short_ticks     = SHORT_RESET;
      measuring       = 1'b0;
      elapsed         = '0;
      sample_phase    = '0;
      release_run     = '0;
      lockout_left    = '0;
      errors          = 0;
      matched         = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
      case (idx)
        CFG_LOCKOUT_TICKS:   lockout_ticks   = val[LockoutWidth-1:0];
        CFG_SAMPLE_TICKS:    sample_ticks    = val[SampleWidth-1:0];
        CFG_RELEASE_SAMPLES: release_samples = val[RunWidth-1:0];
        CFG_LONG_TICKS:      long_ticks      = val[TicksWidth-1:0];
        CFG_SHORT_TICKS:     short_ticks     = val[TicksWidth-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_presses.size();
    endfunction

    function void take_tick(tick_t t);
      if (!measuring) begin
        if (lockout_left != 0) lockout_left--;
        if (!t.press_edge || lockout_left != 0) return;
        measuring    = 1'b1;
        elapsed      = '0;
        sample_phase = '0;
        release_run  = '0;
      end
      if (sample_phase == 0) begin
        if (t.pin_level == PIN_RELEASED) begin
          if (release_run != RUN_MAX) release_run++;
        end else begin
          release_run = '0;
        end
      end
      elapsed = (elapsed >= long_ticks) ? long_ticks : elapsed + 1'b1;
      sample_phase = sample_phase + 1'b1;
      if (sample_phase < sample_ticks) return;
      sample_phase = '0;
      if (release_run < release_samples && elapsed < long_ticks) return;
      measuring    = 1'b0;
      lockout_left = lockout_ticks;
      release_run  = '0;
      if (elapsed >= long_ticks) begin
        expected_presses.push_back('{press_kind: PRESS_LONG, held_ticks: elapsed});
      end else if (elapsed >= short_ticks) begin
        expected_presses.push_back('{press_kind: PRESS_SHORT, held_ticks: elapsed});
      end
    endfunction

    function void check_press(press_t got);
      press_t exp_press;
      if (expected_presses.size() == 0) begin
        $display("%0t: unexpected press, expected none, got kind %0d held %0d",
                 $time, got.press_kind, got.held_ticks);
        errors++;
        return;
      end
      exp_press = expected_presses.pop_front();
      matched++;
      if (got.press_kind !== exp_press.press_kind) begin
        $display("%0t: press_kind expected %0d got %0d",
                 $time, exp_press.press_kind, got.press_kind);
        errors++;
      end
      if (got.held_ticks !== exp_press.held_ticks) begin
        $display("%0t: held_ticks expected %0d got %0d",
                 $time, exp_press.held_ticks, got.held_ticks);
        errors++;
      end
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    tick_valid;
  logic                    tick_stall;
  tick_t                   tick;
  logic                    press_valid;
  logic                    press_stall = 1'b0;
  press_t                  press;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;

  press_tracker tracker = new();
  bit steady = 1'b1;
  int hold_presses = 0;
  int recv_wait = 0;
  int ticks_sent = 0;

  button_press_classifier u_dut (
    .clk         (clk),
    .rst         (rst),
    .tick_valid  (tick_valid),
    .tick_stall  (tick_stall),
    .tick        (tick),
    .press_valid (press_valid),
    .press_stall (press_stall),
    .press       (press),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      press_stall <= 1'b0;
    end else begin
      if (press_valid && !press_stall) begin
        tracker.check_press(press);
        recv_wait = steady ? 0 : $urandom_range(0, 9);
      end
      if (hold_presses > 0) begin
        hold_presses--;
        press_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        press_stall <= 1'b1;
      end else begin
        press_stall <= 1'b0;
      end
    end
  end

  task automatic send_tick(input logic edge_in, input logic pin_in);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      tick_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= '{press_edge: edge_in, pin_level: pin_in};
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    tracker.take_tick('{press_edge: edge_in, pin_level: pin_in});
    ticks_sent++;
  endtask

  task automatic settle();
    tick_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CfgIdxWidth-1:0] idx, input logic [CfgDataWidth-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(idx, val);
  endtask

  function automatic logic [CfgDataWidth-1:0] with_junk(int v, int w);
    logic [CfgDataWidth-1:0] mask;
    mask = (CfgDataWidth'(1) << w) - 1'b1;
    return (CfgDataWidth'(v) & mask) |
           (($urandom_range(0, 3) == 0) ? (CfgDataWidth'($urandom()) & ~mask) : '0);
  endfunction

  task automatic write_regs(input int lk, input int sp, input int rl, input int lg, input int sh);
    settle();
    put_reg(CFG_LOCKOUT_TICKS, with_junk(lk, LockoutWidth));
    put_reg(CFG_SAMPLE_TICKS, with_junk(sp, SampleWidth));
    put_reg(CFG_RELEASE_SAMPLES, with_junk(rl, RunWidth));
    put_reg(CFG_LONG_TICKS, with_junk(lg, TicksWidth));
    put_reg(CFG_SHORT_TICKS, with_junk(sh, TicksWidth));
    if ($urandom_range(0, 3) == 0) put_reg(CFG_UNUSED, CfgDataWidth'($urandom()));
    cfg_valid <= 1'b0;
  endtask

  task automatic press_sequence(input int hold, input int rel_len, input int idle_len,
                                input bit bounce);
    send_tick(1'b1, PIN_PRESSED);
    repeat (hold)
      send_tick($urandom_range(0, 7) == 0,
                (bounce && $urandom_range(0, 9) == 0) ? PIN_RELEASED : PIN_PRESSED);
    repeat (rel_len)
      send_tick($urandom_range(0, 7) == 0,
                (bounce && $urandom_range(0, 9) == 0) ? PIN_PRESSED : PIN_RELEASED);
    repeat (idle_len) send_tick($urandom_range(0, 5) == 0, PIN_RELEASED);
  endtask

  task automatic random_phase();
    int lk, sp, rl, lg, sh, need, hold, rel_len, idle_len, r;
    r  = $urandom_range(0, 9);
    lk = (r == 0) ? 1023 : (r == 1) ? 0 : $urandom_range(0, 12);
    r  = $urandom_range(0, 9);
    sp = (r == 0) ? 63 : (r == 1) ? 0 : $urandom_range(1, 4);
    rl = ($urandom_range(0, 9) == 0) ? 15 : $urandom_range(0, 6);
    r  = $urandom_range(0, 9);
    lg = (r == 0) ? 2047 : (r == 1) ? 0 : $urandom_range(1, 60);
    sh = ($urandom_range(0, 9) == 0) ? 2047 : $urandom_range(0, (lg + 8 > 2047) ? 2047 : lg + 8);
    write_regs(lk, sp, rl, lg, sh);
    steady = ($urandom_range(0, 3) == 0);
    need = (rl + 1) * ((sp == 0) ? 1 : sp);
    repeat ($urandom_range(3, 8)) begin
      if (ticks_sent >= 800) break;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        hold     = $urandom_range(0, (lg + 4 > 150) ? 150 : lg + 4);
        rel_len  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, need)
                                                : need + $urandom_range(0, 4);
        idle_len = (lk > 40 && $urandom_range(0, 3) != 0) ? $urandom_range(0, 8)
                                                          : lk + $urandom_range(0, 6);
        press_sequence(hold, rel_len, idle_len, $urandom_range(0, 1));
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    tick_valid <= 1'b0;
    tick       <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_regs(2, 1, 1, 4, 2);
    send_tick(1'b1, PIN_PRESSED);
    send_tick(1'b1, PIN_PRESSED);
    send_tick(1'b0, PIN_RELEASED);
    send_tick(1'b1, PIN_PRESSED);
    send_tick(1'b1, PIN_PRESSED);
    repeat (3) send_tick(1'b0, PIN_PRESSED);
    send_tick(1'b1, PIN_RELEASED);
    send_tick(1'b0, PIN_RELEASED);
    send_tick(1'b1, PIN_RELEASED);
    write_regs(0, 0, 0, 0, 0);
    send_tick(1'b1, PIN_PRESSED);
    send_tick(1'b1, PIN_RELEASED);
    send_tick(1'b0, PIN_PRESSED);

    // hold off the receiver so the block backs up into the tick side
    write_regs(0, 1, 0, 3, 0);
    hold_presses = 80;
    repeat (40) send_tick(1'b1, 1'($urandom_range(0, 1)));

    write_regs(40, 1, 1, 120, 2047);
    steady = 1'b1;
    press_sequence(125, 3, 45, 1'b0);
    write_regs(0, 63, 3, 2047, 0);
    steady = 1'b1;
    press_sequence(10, 260, 2, 1'b0);

    while (ticks_sent < 800) random_phase();

    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS button_press_classifier");
    end else begin
      $display("FAIL button_press_classifier");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("FAIL button_press_classifier");
    $finish;
  end

endmodule
